// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers; the enclosing scope provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define HSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define HSV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/hsv_pkg.sv =====
package hsv_pkg;

  localparam int FracBits   = 12;
  localparam int NumStages  = 6;
  localparam int NumW       = 20;
  localparam int ProdW      = 32;
  localparam int DenShift   = 6;
  localparam int MW         = ProdW - DenShift;
  localparam int RecipShift = 38;
  localparam int RecipW     = 25;
  localparam int MulW       = MW + RecipW;
  localparam int RemW       = 15;

  localparam logic [FracBits-1:0] FullScale = {FracBits{1'b1}};
  localparam logic [ProdW-1:0]    Half      = ProdW'(300000);
  localparam logic [MW-1:0]       DenOdd    = MW'(9375);
  localparam logic [RecipW-1:0]   Recip     = RecipW'((64'd1 << RecipShift) / 64'd9375);

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] sat_pct;
    logic [6:0] val_pct;
    logic [7:0] alpha_in;
  } hsv_pix_t;

  typedef struct packed {
    logic [11:0] red_out;
    logic [11:0] green_out;
    logic [11:0] blue_out;
    logic [7:0]  alpha_out;
  } hsv_rgb_t;

  typedef struct packed {
    logic [NumW-1:0] r;
    logic [NumW-1:0] g;
    logic [NumW-1:0] b;
  } hsv_num_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } hsv_adv_t;

endpackage

// ===== sv/hsv_front.sv =====
module hsv_front import hsv_pkg::*; (
  input  logic     clk_i,
  input  hsv_adv_t adv_i,
  input  hsv_pix_t pix_i,
  output hsv_num_t num_o
);

  typedef enum logic [2:0] {
    SecRy = 3'd0,
    SecYg = 3'd1,
    SecGc = 3'd2,
    SecCb = 3'd3,
    SecBm = 3'd4,
    SecMr = 3'd5
  } hsv_sector_e;

  logic [6:0]  sat_c, val_c, t_c;
  logic [8:0]  t_full;
  hsv_sector_e sec_d, sec_q;
  logic [5:0]  ramp_d, ramp_q;
  logic [13:0] sv_d, sv_q, vms_d, vms_q;

  logic [NumW-1:0] cn, xn, mn;
  hsv_num_t        num_d, num_q;

  always_comb begin
    sat_c = (pix_i.sat_pct > 7'd100) ? 7'd100 : pix_i.sat_pct;
    val_c = (pix_i.val_pct > 7'd100) ? 7'd100 : pix_i.val_pct;

    if (pix_i.hue_deg >= 9'd480) begin
      t_full = pix_i.hue_deg - 9'd480;
    end else if (pix_i.hue_deg >= 9'd360) begin
      t_full = pix_i.hue_deg - 9'd360;
    end else if (pix_i.hue_deg >= 9'd240) begin
      t_full = pix_i.hue_deg - 9'd240;
    end else if (pix_i.hue_deg >= 9'd120) begin
      t_full = pix_i.hue_deg - 9'd120;
    end else begin
      t_full = pix_i.hue_deg;
    end
    t_c    = t_full[6:0];
    ramp_d = (t_c <= 7'd60) ? t_c[5:0] : 6'(7'd120 - t_c);

    if (pix_i.hue_deg < 9'd60) begin
      sec_d = SecRy;
    end else if (pix_i.hue_deg < 9'd120) begin
      sec_d = SecYg;
    end else if (pix_i.hue_deg < 9'd180) begin
      sec_d = SecGc;
    end else if (pix_i.hue_deg < 9'd240) begin
      sec_d = SecCb;
    end else if (pix_i.hue_deg < 9'd300) begin
      sec_d = SecBm;
    end else begin
      sec_d = SecMr;
    end

    sv_d  = 14'(sat_c) * 14'(val_c);
    vms_d = 14'(val_c) * 14'(7'd100 - sat_c);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en[0]) begin
      sec_q  <= sec_d;
      ramp_q <= ramp_d;
      sv_q   <= sv_d;
      vms_q  <= vms_d;
    end
  end

  always_comb begin
    cn = NumW'(sv_q) * NumW'(60);
    xn = NumW'(sv_q) * NumW'(ramp_q);
    mn = NumW'(vms_q) * NumW'(60);
    case (sec_q)
      SecRy: begin
        num_d.r = cn + mn;
        num_d.g = xn + mn;
        num_d.b = mn;
      end
      SecYg: begin
        num_d.r = xn + mn;
        num_d.g = cn + mn;
        num_d.b = mn;
      end
      SecGc: begin
        num_d.r = mn;
        num_d.g = cn + mn;
        num_d.b = xn + mn;
      end
      SecCb: begin
        num_d.r = mn;
        num_d.g = xn + mn;
        num_d.b = cn + mn;
      end
      SecBm: begin
        num_d.r = xn + mn;
        num_d.g = mn;
        num_d.b = cn + mn;
      end
      default: begin
        num_d.r = cn + mn;
        num_d.g = mn;
        num_d.b = xn + mn;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en[1]) begin
      num_q <= num_d;
    end
  end

  assign num_o = num_q;

endmodule

// ===== sv/hsv_div.sv =====
module hsv_div import hsv_pkg::*; (
  input  logic                clk_i,
  input  hsv_adv_t            adv_i,
  input  logic [NumW-1:0]     num_i,
  output logic [FracBits-1:0] q_o
);

  logic [ProdW-1:0]    prod;
  logic [MW-1:0]       m3_d, m3_q, m4_q, diff;
  logic [MulW-1:0]     mr;
  logic [FracBits-1:0] q0_d, q0_q, q05_q, q_d, q_q;
  logic [RemW-1:0]     rem_d, rem_q;

  always_comb begin
    prod = ProdW'(num_i) * ProdW'(FullScale) + Half;
    m3_d = prod[ProdW-1:DenShift];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en[2]) begin
      m3_q <= m3_d;
    end
  end

  always_comb begin
    mr   = MulW'(m3_q) * MulW'(Recip);
    q0_d = mr[RecipShift +: FracBits];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en[3]) begin
      q0_q <= q0_d;
      m4_q <= m3_q;
    end
  end

  always_comb begin
    diff  = m4_q - MW'(q0_q) * DenOdd;
    rem_d = diff[RemW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en[4]) begin
      q05_q <= q0_q;
      rem_q <= rem_d;
    end
  end

  assign q_d = q05_q + FracBits'(rem_q >= DenOdd[RemW-1:0]);

  always_ff @(posedge clk_i) begin
    if (adv_i.en[5]) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | in_pix_i  (hsv_pix_t)
// out     | output    | out_valid_o / out_stall_i | out_rgb_o (hsv_rgb_t)
//
// Accepts one pixel per cycle while in_stall_o is low.
// The six register stages (sector and products, numerator select, scale,
// reciprocal multiply, remainder, correction) set the latency.
// Reset clears only the stage valid bits; data registers keep their contents.
// A stall fills empty stages first, so in_stall_o rises only when every stage holds a pixel.
module hsv_to_rgb_converter import hsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hsv_pix_t in_pix_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hsv_rgb_t out_rgb_o
);

  logic [NumStages-1:0] valid_q, ready;
  logic [7:0]           alpha_q [NumStages];
  hsv_adv_t             adv;
  hsv_num_t             num;
  logic [FracBits-1:0]  red, green, blue;

  always_comb begin
    ready[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    adv.en = ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      alpha_q[0] <= in_pix_i.alpha_in;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ready[k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  hsv_front u_front (
    .clk_i (clk_i),
    .adv_i (adv),
    .pix_i (in_pix_i),
    .num_o (num)
  );

  hsv_div u_div_r (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (num.r),
    .q_o   (red)
  );

  hsv_div u_div_g (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (num.g),
    .q_o   (green)
  );

  hsv_div u_div_b (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (num.b),
    .q_o   (blue)
  );

  assign in_stall_o            = !ready[0];
  assign out_valid_o           = valid_q[NumStages-1];
  assign out_rgb_o.red_out     = red;
  assign out_rgb_o.green_out   = green;
  assign out_rgb_o.blue_out    = blue;
  assign out_rgb_o.alpha_out   = alpha_q[NumStages-1];

endmodule

// ===== sv/hsv_checker.sv =====
`include "assert_macros.svh"

module hsv_checker import hsv_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input hsv_rgb_t out_rgb_o
);

  `HSV_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rgb_o), "stalled output transfer changed")
  `HSV_ASSERT(a_stall_full, in_stall_o |-> out_valid_o && out_stall_i, "input stalled while pipeline has room")
  `HSV_ASSERT(a_no_drop, $fell(out_valid_o) |-> $past(!out_stall_i), "output dropped without a transfer")
  `HSV_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_o, "output valid during reset")

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (.*);

// ===== test/tb_hsv_to_rgb_converter.sv =====
module tb_hsv_to_rgb_converter;
  import hsv_pkg::*;

  localparam int unsigned NumRandom  = 600;
  localparam int unsigned HoldAt     = 150;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned ColorMax   = 4095;
  localparam int unsigned DenTotal   = 600000;

  typedef enum logic [2:0] {
    SectRedYellow,
    SectYellowGreen,
    SectGreenCyan,
    SectCyanBlue,
    SectBlueMagenta,
    SectMagentaRed
  } hue_sector_e;

  typedef struct {
    hsv_pix_t    pix;
    int unsigned gap;
    bit          drain;
  } pix_job_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  hsv_pix_t in_pix_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  hsv_rgb_t out_rgb_o;

  pix_job_t    pix_jobs_q[$];
  hsv_rgb_t    rgb_expected_q[$];
  int unsigned n_sent = 0;
  int unsigned n_recv = 0;
  int unsigned n_fail = 0;
  int unsigned n_items = 0;
  int unsigned gap_left = 0;
  bit          gap_loaded = 1'b0;
  int unsigned stall_left = 0;

  hsv_to_rgb_converter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_pix_i   (in_pix_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rgb_o  (out_rgb_o)
  );

  function automatic logic [11:0] scale_color(longint unsigned num);
    return 12'(((num * ColorMax) + (DenTotal / 2)) / DenTotal);
  endfunction

  function automatic hsv_rgb_t rgb_from_hsv(hsv_pix_t p);
    longint unsigned h, s, v, t, ramp, cn, xn, mn, rn, gn, bn;
    hue_sector_e sector;
    hsv_rgb_t res;
    h = p.hue_deg;
    s = (p.sat_pct > 100) ? 100 : p.sat_pct;
    v = (p.val_pct > 100) ? 100 : p.val_pct;
    t = h % 120;
    ramp = (t <= 60) ? t : (120 - t);
    cn = s * v * 60;
    xn = s * v * ramp;
    mn = v * (100 - s) * 60;
    sector = (h < 360) ? hue_sector_e'(h / 60) : SectMagentaRed;
    case (sector)
      SectRedYellow: begin
        rn = cn; gn = xn; bn = 0;
      end
      SectYellowGreen: begin
        rn = xn; gn = cn; bn = 0;
      end
      SectGreenCyan: begin
        rn = 0; gn = cn; bn = xn;
      end
      SectCyanBlue: begin
        rn = 0; gn = xn; bn = cn;
      end
      SectBlueMagenta: begin
        rn = xn; gn = 0; bn = cn;
      end
      default: begin
        rn = cn; gn = 0; bn = xn;
      end
    endcase
    res.red_out   = scale_color(rn + mn);
    res.green_out = scale_color(gn + mn);
    res.blue_out  = scale_color(bn + mn);
    res.alpha_out = p.alpha_in;
    return res;
  endfunction

  function automatic int unsigned idle_draw(bit quiet);
    if (quiet || $urandom_range(1, 0) == 0) return 0;
    return $urandom_range(13, 0);
  endfunction

  function automatic hsv_pix_t random_pixel();
    hsv_pix_t p;
    p.alpha_in = 8'($urandom_range(255, 0));
    if ($urandom_range(4, 0) != 0) begin
      p.hue_deg = 9'($urandom_range(359, 0));
      p.sat_pct = 7'($urandom_range(100, 0));
      p.val_pct = 7'($urandom_range(100, 0));
    end else begin
      p.hue_deg = 9'($urandom_range(511, 0));
      p.sat_pct = 7'($urandom_range(127, 0));
      p.val_pct = 7'($urandom_range(127, 0));
    end
    return p;
  endfunction

  task automatic add_pixel(hsv_pix_t p, int unsigned gap, bit drain);
    pix_job_t job;
    job.pix   = p;
    job.gap   = gap;
    job.drain = drain;
    pix_jobs_q.insert(pix_jobs_q.size(), job);
    n_items++;
  endtask

  task automatic add_hsv(int unsigned h, int unsigned s, int unsigned v, int unsigned a);
    hsv_pix_t p;
    p.hue_deg  = 9'(h);
    p.sat_pct  = 7'(s);
    p.val_pct  = 7'(v);
    p.alpha_in = 8'(a);
    add_pixel(p, idle_draw(1'b0), 1'b0);
  endtask

  task automatic check_field(string name, logic [11:0] exp_val, logic [11:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      n_fail++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  // driver
  always @(posedge clk_i) begin : drive
    bit          hold;
    bit          xfer;
    int unsigned sent_now;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_loaded = 1'b0;
    end else begin
      xfer = in_valid_i && !in_stall_o;
      hold = in_valid_i && in_stall_o;
      sent_now = n_sent;
      if (xfer) begin
        rgb_expected_q.insert(rgb_expected_q.size(), rgb_from_hsv(in_pix_i));
        sent_now = n_sent + 1;
        n_sent <= sent_now;
      end
      if (!hold) begin
        if (!gap_loaded && pix_jobs_q.size() != 0) begin
          gap_left = pix_jobs_q[0].gap;
          gap_loaded = 1'b1;
        end
        if (!gap_loaded) begin
          in_valid_i <= 1'b0;
        end else if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pix_jobs_q[0].drain && sent_now != n_recv) begin
          in_valid_i <= 1'b0;
        end else begin
          in_pix_i   <= pix_jobs_q[0].pix;
          in_valid_i <= 1'b1;
          void'(pix_jobs_q.pop_front());
          gap_loaded = 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch
    hsv_rgb_t exp_rgb;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_recv <= n_recv + 1;
        if (rgb_expected_q.size() == 0) begin
          $error("result transfer with no pixel pending");
          n_fail++;
        end else begin
          exp_rgb = rgb_expected_q.pop_front();
          check_field("red_out",   exp_rgb.red_out,   out_rgb_o.red_out);
          check_field("green_out", exp_rgb.green_out, out_rgb_o.green_out);
          check_field("blue_out",  exp_rgb.blue_out,  out_rgb_o.blue_out);
          check_field("alpha_out", 12'(exp_rgb.alpha_out), 12'(out_rgb_o.alpha_out));
        end
        if (n_recv + 1 == HoldAt) stall_left = HoldCycles;
        else stall_left = idle_draw(n_recv >= 300 && n_recv < 380);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  initial begin
    add_hsv(0, 100, 100, 255);
    add_hsv(59, 100, 100, 0);
    add_hsv(60, 100, 100, 1);
    add_hsv(119, 100, 100, 128);
    add_hsv(120, 100, 100, 64);
    add_hsv(179, 100, 100, 32);
    add_hsv(180, 100, 100, 16);
    add_hsv(239, 100, 100, 8);
    add_hsv(240, 100, 100, 4);
    add_hsv(299, 100, 100, 2);
    add_hsv(300, 100, 100, 170);
    add_hsv(359, 100, 100, 85);
    add_hsv(360, 100, 100, 200);
    add_hsv(420, 60, 90, 100);
    add_hsv(511, 100, 100, 255);
    add_hsv(30, 0, 50, 77);
    add_hsv(200, 80, 0, 99);
    add_hsv(0, 0, 0, 0);
    add_hsv(90, 127, 127, 255);
    add_hsv(150, 101, 100, 12);
    add_hsv(270, 50, 101, 13);
    add_hsv(45, 33, 67, 14);
    add_hsv(330, 50, 50, 15);
    add_hsv(510, 127, 127, 240);
    for (int unsigned i = 0; i < NumRandom; i++) begin
      add_pixel(random_pixel(),
                idle_draw((i >= 120 && i < 280) || (i >= 300 && i < 380)),
                (i == 0) || (i == 450));
    end

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_sent == n_items);
    wait (n_recv == n_sent);
    repeat (20) @(posedge clk_i);
    if (rgb_expected_q.size() != 0) begin
      $error("%0d expected results never arrived", rgb_expected_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
